// File: design/fspa_pkg.sv
// fspa_pkg: shared types and constants of the fixed slot pool allocator
// no dependencies; imported by every module of the allocator

package fspa_pkg;

  localparam int ID_W   = 7;
  localparam int SIZE_W = 13;
  localparam int OFF_W  = 18;
  localparam int STAT_W = 2;
  localparam int REQ_W  = 2;

  localparam logic [SIZE_W-1:0] MAX_SLOT_BYTES = 13'd4096;
  localparam logic [SIZE_W-1:0] ALIGN_MASK     = 13'd7;
  localparam logic [SIZE_W-1:0] RESET_BYTES    = 13'd8;
  localparam logic [ID_W-1:0]   RESET_COUNT    = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_LIST  = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic {
    CFG_SLOT_COUNT = 1'b0,
    CFG_SLOT_BYTES = 1'b1
  } cfg_idx_t;

  // one word of the link memory: allocated mark beside the next-free link
  typedef struct packed {
    logic            mark;
    logic [ID_W-1:0] link;
  } entry_t;

  // one result going from the controller to the output stage
  typedef struct packed {
    logic [ID_W-1:0] id;
    status_t         status;
    logic            last;
  } res_t;

endpackage

// File: design/fixed_slot_pool_allocator.sv
// fixed_slot_pool_allocator: top level of the fixed slot pool allocator
// instantiates fspa_ctrl, fspa_link_mem and fspa_out; uses fspa_pkg
//
//   channel  | direction | content
//   ---------+-----------+-------------------------------------------------
//   s_*      | in        | request: tuser req_type, tdata slot_id
//   m_*      | out       | result: tdata id/offset/status, tlast on final
//   cfg_*    | in        | register write: index, data
//
// alloc and free read the slot's memory word at the request transaction and
// write it back as the result moves on: the result passes from the S_ALLOC
// or S_FREE state into the output register; init gives no result.
// a list reads one slot word per cycle while the result side does not stall.
// requests are taken one at a time; the next one is accepted while the
// previous result still sits in the output register.
// synchronous reset restores the pool of 64 (clamped) slots of 8 bytes;
// no clearing pass: slots at the watermark or above count as free and
// linked in id order, so their memory words are never used before written.

module fixed_slot_pool_allocator
  import fspa_pkg::*;
#(
  parameter int NUM_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [6:0] slot_id, [7] zero
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [6:0] result_id, [24:7] byte_offset,
                                 // [26:25] status, [31:27] zero
  output logic        m_tlast,   // last
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index, // 0 slot_count, 1 slot_bytes
  input  logic [12:0] cfg_data
);

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  entry_t            mem_wdata;
  logic [AW-1:0]     mem_raddr;
  entry_t            mem_rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic [SIZE_W-1:0] act_size;

  // registers are always writable; they take effect at the next init
  assign cfg_ready = 1'b1;

  fspa_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req_type  (req_t'(s_tuser)),
    .req_id    (s_tdata[ID_W-1:0]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_sel   (cfg_idx_t'(cfg_index)),
    .cfg_wdata (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .act_size  (act_size)
  );

  // next-slot links and allocated marks of popped slots; fresh slots follow in id order
  fspa_link_mem #(
    .DEPTH (NUM_SLOTS),
    .AW    (AW)
  ) u_link_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fspa_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .act_size  (act_size),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// File: design/fspa_link_mem.sv
// fspa_link_mem: per-slot memory of next-free link and allocated mark
// one write port, one read port, registered read data; uses fspa_pkg

module fspa_link_mem
  import fspa_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/fspa_ctrl.sv
// fspa_ctrl: request sequencer, free list head and fresh watermark
// drives fspa_link_mem and hands results to fspa_out; uses fspa_pkg

module fspa_ctrl
  import fspa_pkg::*;
#(
  parameter int NUM_SLOTS = 64,
  parameter int AW        = 6
) (
  input  logic              clk,
  input  logic              rst,
  // request
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req_type,
  input  logic [ID_W-1:0]   req_id,
  // register writes
  input  logic              cfg_we,
  input  cfg_idx_t          cfg_sel,
  input  logic [SIZE_W-1:0] cfg_wdata,
  // link memory
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output entry_t            mem_wdata,
  output logic [AW-1:0]     mem_raddr,
  input  entry_t            mem_rdata,
  // result
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  output logic [SIZE_W-1:0] act_size
);

  localparam logic [ID_W-1:0] MAX_CNT = ID_W'(NUM_SLOTS);

  typedef enum logic [1:0] {
    S_IDLE, S_ALLOC, S_FREE, S_LIST
  } state_t;

  state_t                 state;
  logic [ID_W-1:0]        slot_count;
  logic [SIZE_W-1:0]      slot_bytes;
  logic [ID_W-1:0]        act_count;
  logic [ID_W-1:0]        head;
  logic [ID_W-1:0]        wm;       // slots at or above this were never popped since init
  logic [ID_W-1:0]        cur_id;
  logic [ID_W-1:0]        scan_cnt;
  logic [ID_W-1:0]        pend;     // found slot waiting to be emitted

  logic [ID_W-1:0]        cnt_clamped;
  logic [SIZE_W-1:0]      bytes_clamped;
  logic [SIZE_W-1:0]      size_aligned;
  logic [AW-1:0]          cur_idx;
  logic [AW-1:0]          head_idx;
  logic [AW-1:0]          req_idx;
  logic [ID_W-1:0]        scan_id;
  logic                   pool_empty;
  logic                   head_fresh;
  logic [ID_W-1:0]        head_next;
  logic                   free_range;
  logic                   free_ok;
  logic                   scan_mark;
  logic                   scan_adv;
  logic                   scan_done;

  always_comb begin
    if (slot_count == '0) begin
      cnt_clamped = ID_W'(1);
    end else if (slot_count > MAX_CNT) begin
      cnt_clamped = MAX_CNT;
    end else begin
      cnt_clamped = slot_count;
    end
    bytes_clamped = (slot_bytes > MAX_SLOT_BYTES) ? MAX_SLOT_BYTES : slot_bytes;
    size_aligned  = (bytes_clamped + ALIGN_MASK) & ~ALIGN_MASK;
  end

  assign cur_idx    = AW'(cur_id - ID_W'(1));
  assign head_idx   = AW'(head - ID_W'(1));
  assign req_idx    = AW'(req_id - ID_W'(1));
  assign scan_id    = scan_cnt + ID_W'(1);
  assign pool_empty = (head == '0) || (head > act_count);
  assign head_fresh = (head >= wm);
  assign head_next  = head_fresh ? ((head < act_count) ? head + ID_W'(1) : '0)
                                 : mem_rdata.link;
  // marks below the watermark are valid, the rest count as clear since init
  assign free_range = (cur_id > act_count);
  assign free_ok    = !free_range && mem_rdata.mark && (cur_id < wm);
  assign scan_mark  = mem_rdata.mark && (scan_id < wm);
  assign scan_done  = (scan_cnt == act_count);
  assign scan_adv   = !scan_done && (!scan_mark || pend == '0 || res_ready);

  assign req_ready = (state == S_IDLE);

  // read address: the word the next cycle needs, held while a result stalls
  always_comb begin
    mem_raddr = head_idx;
    unique case (state)
      S_IDLE: begin
        if (req_type == REQ_FREE) begin
          mem_raddr = req_idx;
        end else if (req_type == REQ_LIST) begin
          mem_raddr = '0;
        end
      end
      S_ALLOC: mem_raddr = head_idx;
      S_FREE:  mem_raddr = cur_idx;
      S_LIST:  mem_raddr = scan_adv ? scan_id[AW-1:0] : scan_cnt[AW-1:0];
    endcase
  end

  // write back when the result moves on: alloc sets the mark, free clears
  // it and links the slot to the old head
  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = cur_idx;
    mem_wdata.mark = 1'b0;
    mem_wdata.link = head;
    if ((state == S_ALLOC) && res_ready && !pool_empty) begin
      mem_we         = 1'b1;
      mem_waddr      = head_idx;
      mem_wdata.mark = 1'b1;
      mem_wdata.link = '0;
    end else if ((state == S_FREE) && res_ready && free_ok) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    res_valid  = 1'b0;
    res.id     = '0;
    res.status = ST_OK;
    res.last   = 1'b1;
    unique case (state)
      S_ALLOC: begin
        res_valid = 1'b1;
        if (pool_empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.id = head;
        end
      end
      S_FREE: begin
        res_valid = 1'b1;
        if (free_range) begin
          res.status = ST_RANGE;
        end else if (!free_ok) begin
          res.status = ST_NOT_ALLOC;
        end else begin
          res.id = cur_id;
        end
      end
      S_LIST: begin
        if (scan_done) begin
          res_valid = 1'b1;
          res.id    = pend;
        end else if (scan_mark && pend != '0) begin
          res_valid = 1'b1;
          res.id    = pend;
          res.last  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_count <= RESET_COUNT;
      slot_bytes <= RESET_BYTES;
      act_count  <= (RESET_COUNT > MAX_CNT) ? MAX_CNT : RESET_COUNT;
      act_size   <= RESET_BYTES;
      head       <= ID_W'(1);
      wm         <= ID_W'(1);
      cur_id     <= '0;
      scan_cnt   <= '0;
      pend       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_sel)
          CFG_SLOT_COUNT: slot_count <= cfg_wdata[ID_W-1:0];
          CFG_SLOT_BYTES: slot_bytes <= cfg_wdata;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur_id   <= req_id;
            scan_cnt <= '0;
            pend     <= '0;
            unique case (req_type)
              REQ_INIT: begin
                act_count <= cnt_clamped;
                act_size  <= size_aligned;
                head      <= ID_W'(1);
                wm        <= ID_W'(1);
              end
              REQ_ALLOC: state <= S_ALLOC;
              REQ_FREE:  state <= (req_id == '0) ? S_IDLE : S_FREE;
              REQ_LIST:  state <= S_LIST;
            endcase
          end
        end
        S_ALLOC: begin
          if (res_ready) begin
            state <= S_IDLE;
            if (!pool_empty) begin
              head <= head_next;
              if (head_fresh) begin
                wm <= head + ID_W'(1);
              end
            end
          end
        end
        S_FREE: begin
          if (res_ready) begin
            state <= S_IDLE;
            if (free_ok) begin
              head <= cur_id;
            end
          end
        end
        S_LIST: begin
          if (scan_done) begin
            if (res_ready) begin
              state <= S_IDLE;
            end
          end else if (scan_adv) begin
            scan_cnt <= scan_id;
            if (scan_mark) begin
              pend <= scan_id;
            end
          end
        end
      endcase
    end
  end

endmodule

// File: design/fspa_out.sv
// fspa_out: offset multiply and output register of the result stream
// fed by fspa_ctrl; uses fspa_pkg

module fspa_out
  import fspa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  output logic              res_ready,
  input  res_t              res,
  input  logic [SIZE_W-1:0] act_size,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,
  output logic              m_tlast
);

  localparam int PROD_W = ID_W + SIZE_W;

  logic [PROD_W-1:0] prod;
  logic [ID_W-1:0]   out_id;
  logic [OFF_W-1:0]  out_off;
  status_t           out_stat;

  assign res_ready = !m_tvalid || m_tready;
  assign prod = (res.id == '0) ? '0
                : PROD_W'(res.id - ID_W'(1)) * PROD_W'(act_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_id   <= res.id;
      out_off  <= prod[OFF_W-1:0];
      out_stat <= res.status;
      m_tlast  <= res.last;
    end
  end

  assign m_tdata = {5'd0, out_stat, out_off, out_id};

endmodule

// File: design/fspa_checker.sv
// fspa_checker: port level checks of the fixed slot pool allocator
// bound to fixed_slot_pool_allocator; uses fspa_pkg

module fspa_checker
  import fspa_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // error results carry no id, no offset and end the request
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[26:25] != ST_OK |->
      m_tdata[6:0] == 7'd0 && m_tdata[24:7] == 18'd0 && m_tlast)
    else $error("error result with id or offset");

  // an empty id always has a zero offset and ends the request
  a_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6:0] == 7'd0 |-> m_tdata[24:7] == 18'd0 && m_tlast)
    else $error("empty id with offset");

  // offsets are multiples of eight, padding is zero
  a_align: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[9:7] == 3'd0 && m_tdata[31:27] == 5'd0)
    else $error("misaligned offset or dirty padding");

  // a request that gives a result leaves the request side not ready right after it
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == REQ_ALLOC || s_tuser == REQ_LIST ||
      (s_tuser == REQ_FREE && s_tdata[6:0] != 7'd0)) |=> !s_tready)
    else $error("request side ready right after a request with results");

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (.*);

// File: tb/sv/tb_fixed_slot_pool_allocator.sv
`timescale 1ns / 1ps
// tb_fixed_slot_pool_allocator: self-checking testbench of the slot pool allocator
// keeps its own model of the free list and checks every result transaction
// depends on fspa_pkg and fixed_slot_pool_allocator

module tb_fixed_slot_pool_allocator;
  import fspa_pkg::*;

  localparam int NUM_SLOTS = 64;
  // a list walks the whole pool, so settle() waits out a walk of the pool before touching registers
  localparam int SETTLE_CYCLES = NUM_SLOTS + 8;
  localparam int MAX_ID_VALUE = 127;

  // one expected result transaction
  typedef struct {
    logic [ID_W-1:0]  id;
    logic [OFF_W-1:0] offset;
    status_t          status;
    logic             is_last;
  } pool_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [6:0] slot_id, [7] zero
  logic [1:0]  s_tuser = '0;   // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [6:0] result_id, [24:7] byte_offset, [26:25] status
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [12:0] cfg_data = '0;

  pool_reply_t pending_replies[$];
  int          mismatches = 0;
  bit          quiet = 1'b0;   // no idling on either side while set

  // model of the pool: link memory, allocated marks and free list head
  logic [ID_W-1:0]   link_of [1:NUM_SLOTS];
  bit                in_use  [1:NUM_SLOTS];
  logic [ID_W-1:0]   head_id;
  int                live_count;
  int                live_size;
  // register contents, latched into live_count/live_size only by init
  logic [ID_W-1:0]   count_reg;
  logic [SIZE_W-1:0] bytes_reg;

  fixed_slot_pool_allocator #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // result side stalls about 7 percent of the time, never while quiet is set
  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 7);
  end

  // ---------------------------------------------------------------------------
  // pool model
  // ---------------------------------------------------------------------------

  // init: clamp count to 1..NUM_SLOTS, clamp size to 4096 and round up to 8,
  // link slots in ascending order and clear every allocated mark
  function automatic void rebuild_pool();
    int b;
    if (count_reg == 0) live_count = 1;
    else if (count_reg > NUM_SLOTS) live_count = NUM_SLOTS;
    else live_count = int'(count_reg);
    b = (bytes_reg > MAX_SLOT_BYTES) ? int'(MAX_SLOT_BYTES) : int'(bytes_reg);
    live_size = (b + int'(ALIGN_MASK)) & ~int'(ALIGN_MASK);
    for (int i = 1; i <= NUM_SLOTS; i++) begin
      link_of[i] = (i < live_count) ? ID_W'(i + 1) : '0;
      in_use[i] = 1'b0;
    end
    head_id = ID_W'(1);
  endfunction

  // offset follows the size latched at the last init; id 0 has offset 0
  function automatic void expect_reply(int id, status_t st, bit is_last);
    pool_reply_t r;
    r.id = ID_W'(id);
    r.offset = (id == 0) ? '0 : OFF_W'((id - 1) * live_size);
    r.status = st;
    r.is_last = is_last;
    pending_replies.push_back(r);
  endfunction

  function automatic void model_request(req_t r, int id);
    int top;
    top = 0;
    case (r)
      REQ_INIT: begin
        rebuild_pool();
      end
      REQ_ALLOC: begin
        if (head_id == 0 || head_id > live_count) begin
          expect_reply(0, ST_EMPTY, 1'b1);
        end else begin
          top = int'(head_id);
          head_id = link_of[top];
          in_use[top] = 1'b1;
          expect_reply(top, ST_OK, 1'b1);
        end
      end
      REQ_FREE: begin
        // id 0 is dropped without a result
        if (id != 0) begin
          if (id > live_count) begin
            expect_reply(0, ST_RANGE, 1'b1);
          end else if (!in_use[id]) begin
            expect_reply(0, ST_NOT_ALLOC, 1'b1);
          end else begin
            in_use[id] = 1'b0;
            link_of[id] = head_id;
            head_id = ID_W'(id);
            expect_reply(id, ST_OK, 1'b1);
          end
        end
      end
      default: begin
        // list: ascending ids, last flag on the highest one
        for (int i = 1; i <= live_count; i++) begin
          if (in_use[i]) top = i;
        end
        if (top == 0) begin
          expect_reply(0, ST_OK, 1'b1);
        end else begin
          for (int i = 1; i <= top; i++) begin
            if (in_use[i]) expect_reply(i, ST_OK, i == top);
          end
        end
      end
    endcase
  endfunction

  // an allocated slot where there is one, else any slot of the pool
  function automatic int pick_victim();
    int ids[$];
    for (int i = 1; i <= live_count; i++) begin
      if (in_use[i]) ids.push_back(i);
    end
    if (ids.size() == 0) return $urandom_range(live_count, 1);
    return ids[$urandom_range(ids.size() - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // outputs are stable between edges: a transaction seen here completes at
  // the next rising edge
  always @(negedge clk) begin : check_replies
    pool_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual tdata=%h tlast=%b",
                 $time, m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        compare_field("result_id", int'(want.id), int'(m_tdata[6:0]));
        compare_field("byte_offset", int'(want.offset), int'(m_tdata[24:7]));
        compare_field("status", int'(want.status), int'(m_tdata[26:25]));
        compare_field("tdata pad", 0, int'(m_tdata[31:27]));
        compare_field("last", int'(want.is_last), int'(m_tlast));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // tvalid is left high after the transaction so that a request that follows
  // at once keeps it up; settle() or a gap lowers it
  task automatic send_req(req_t r, int id);
    bit hit;
    if (!quiet) begin
      while ($urandom_range(99) < 7) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= r;
    s_tdata <= {1'b0, ID_W'(id)};
    do begin
      @(negedge clk);
      hit = s_tready;
      @(posedge clk);
    end while (!hit);
    model_request(r, id);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [12:0] value);
    bit hit;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(negedge clk);
      hit = cfg_ready;
      @(posedge clk);
    end while (!hit);
    if (idx == CFG_SLOT_COUNT) count_reg = value[ID_W-1:0];
    else bytes_reg = value;
  endtask

  // wait for every expected result, then for any request that gives none
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // registers are only written with the block idle
  task automatic set_regs(int count, int bytes);
    settle();
    write_reg(CFG_SLOT_COUNT, 13'(count));
    write_reg(CFG_SLOT_BYTES, 13'(bytes));
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request(int alloc_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < alloc_pct) send_req(REQ_ALLOC, $urandom_range(MAX_ID_VALUE));
    else if (roll < alloc_pct + 25) send_req(REQ_FREE, pick_victim());
    else if (roll < alloc_pct + 35) send_req(REQ_FREE, $urandom_range(MAX_ID_VALUE));
    else if (roll < alloc_pct + 45) send_req(REQ_LIST, $urandom_range(MAX_ID_VALUE));
    else if (roll < alloc_pct + 48) send_req(REQ_INIT, $urandom_range(MAX_ID_VALUE));
    else send_req(REQ_ALLOC, 0);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // pool as left by reset: 64 slots of 8 bytes
  task automatic test_reset_defaults();
    send_req(REQ_LIST, 0);          // nothing allocated yet
    send_req(REQ_ALLOC, 0);
    send_req(REQ_ALLOC, 0);
    send_req(REQ_ALLOC, 0);
    send_req(REQ_FREE, 0);          // id 0 is ignored
    send_req(REQ_FREE, 2);
    send_req(REQ_FREE, 2);          // double free
    send_req(REQ_FREE, 64);         // in range but never allocated
    send_req(REQ_FREE, 65);         // out of range
    send_req(REQ_FREE, MAX_ID_VALUE);
    send_req(REQ_ALLOC, 0);         // last in, first out
    send_req(REQ_LIST, 0);
  endtask

  // clamping of both registers and the deferred effect of a write
  task automatic test_register_extremes();
    set_regs(0, 0);
    send_req(REQ_ALLOC, 0);         // old size until the next init
    send_req(REQ_INIT, 0);
    send_req(REQ_ALLOC, 0);         // size 0: offset 0
    send_req(REQ_ALLOC, 0);         // one slot only: empty
    send_req(REQ_FREE, 2);
    send_req(REQ_LIST, 0);
    send_req(REQ_FREE, 1);
    send_req(REQ_LIST, 0);
    set_regs(65, 1);
    send_req(REQ_INIT, 0);
    send_req(REQ_ALLOC, 0);
    send_req(REQ_ALLOC, 0);
    set_regs(2, 4096);
    send_req(REQ_INIT, 0);
    send_req(REQ_ALLOC, 0);
    send_req(REQ_ALLOC, 0);
    send_req(REQ_ALLOC, 0);
  endtask

  // largest register values, no idling: fill the pool until it runs empty
  task automatic test_full_pool();
    int sent;
    sent = 0;
    set_regs(MAX_ID_VALUE, 8191);
    quiet = 1'b1;
    send_req(REQ_INIT, 0);
    while (head_id != 0 && sent < 150) begin
      random_request(85);
      sent++;
    end
    send_req(REQ_ALLOC, 0);
    send_req(REQ_LIST, 0);
    send_req(REQ_FREE, NUM_SLOTS);
    send_req(REQ_FREE, pick_victim());
    send_req(REQ_ALLOC, 0);
    quiet = 1'b0;
  endtask

  // mostly small pools with random sizes, one phase with any count
  task automatic test_random_mix();
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 2) set_regs($urandom_range(MAX_ID_VALUE), $urandom_range(8191));
      else set_regs($urandom_range(12, 1), $urandom_range(8191));
      send_req(REQ_INIT, $urandom_range(MAX_ID_VALUE));
      repeat (20) random_request(45);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    count_reg = RESET_COUNT;
    bytes_reg = RESET_BYTES;
    rebuild_pool();
    test_reset_defaults();
    test_register_extremes();
    test_full_pool();
    test_random_mix();
    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
